[rtl/core/stp_pkg.sv]
// Shared constants and types for the segment/triangle intersection block.
package stp_pkg;

  // Default coordinate width: signed Q11.12
  localparam int CoordWidthDef = 24;
  // Fraction output: signed Q15.16
  localparam int FracWidth = 32;
  localparam int OutFrac   = 16;
  // Quotient bits produced by the restoring divider (one per stage)
  localparam int QBits     = 34;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_TEST = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    VSEL_A = 2'd0,
    VSEL_B = 2'd1,
    VSEL_C = 2'd2,
    VSEL_NONE = 2'd3
  } vsel_e;

  // Per-item decision flags carried alongside the divider
  typedef struct packed {
    logic hit;
    logic neg;
    logic zero;
    logic big;
  } stp_flags_t;

endpackage

[rtl/core/stp_if.sv]
// Valid/ready channel interfaces for segment words and result words.
interface stp_in_if
  import stp_pkg::*;
#(
  parameter int W = CoordWidthDef
);
  logic                valid;
  logic                ready;
  logic                kind;
  logic [1:0]          vertex_sel;
  logic signed [W-1:0] first_x;
  logic signed [W-1:0] first_y;
  logic signed [W-1:0] first_z;
  logic signed [W-1:0] end_x;
  logic signed [W-1:0] end_y;
  logic signed [W-1:0] end_z;

  modport source (
    output valid, kind, vertex_sel, first_x, first_y, first_z, end_x, end_y, end_z,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex_sel, first_x, first_y, first_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface stp_out_if
  import stp_pkg::*;
;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic signed [FracWidth-1:0] fraction;

  modport source (
    output valid, hit, fraction,
    input  ready
  );
  modport sink (
    input  valid, hit, fraction,
    output ready
  );
endinterface

[rtl/core/segment_triangle_intersect_top.sv]
// Segment/triangle intersection test against one stored triangle.
// Load words write one vertex (a, b or c) into the triangle store and take
// effect for the next word; they give no result. Every test word gives one
// result: hit and the crossing parameter f in signed Q15.16, rounded and
// saturated. All arithmetic is exact integer math. One word is taken every
// cycle while the pipeline is not stalled; a result passes through the
// cross/dot product stages and the 34-stage restoring divider, which yields
// one quotient bit per stage. An output register and a skid register
// decouple the two sides; the pipeline stalls as a whole only while the
// skid register is full.
module segment_triangle_intersect_top
  import stp_pkg::*;
#(
  parameter int COORD_WIDTH = CoordWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  stp_in_if.sink    in_i,
  stp_out_if.source out_o
);
  localparam int W   = COORD_WIDTH;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int SW  = 3 * DW + 2;
  localparam int LAT = 8 + QBits;

  logic en;
  logic take;
  logic [LAT-1:0] vld_q;

  // Output register with skid register behind it
  logic                 out_vld_q;
  logic                 out_hit_q;
  logic [FracWidth-1:0] out_frac_q;
  logic                 skid_vld_q;
  logic                 skid_hit_q;
  logic [FracWidth-1:0] skid_frac_q;

  // Triangle store: a.xyz, b.xyz, c.xyz
  logic signed [W-1:0] vtx_q [9];

  assign en         = !skid_vld_q;
  assign in_i.ready = en;
  assign take       = in_i.valid && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) vtx_q[i] <= '0;
    end else if (take && in_i.kind == KIND_LOAD) begin
      case (in_i.vertex_sel)
        VSEL_A: begin
          vtx_q[0] <= in_i.first_x; vtx_q[1] <= in_i.first_y; vtx_q[2] <= in_i.first_z;
        end
        VSEL_B: begin
          vtx_q[3] <= in_i.first_x; vtx_q[4] <= in_i.first_y; vtx_q[5] <= in_i.first_z;
        end
        VSEL_C: begin
          vtx_q[6] <= in_i.first_x; vtx_q[7] <= in_i.first_y; vtx_q[8] <= in_i.first_z;
        end
        default: begin
        end
      endcase
    end
  end

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], take && (in_i.kind == KIND_TEST)};
    end
  end

  // Stage 1: edge, direction and offset vectors
  logic signed [W-1:0]  p1 [3];
  logic signed [W-1:0]  p2 [3];
  logic signed [DW-1:0] d1_q [3];
  logic signed [DW-1:0] s1_q [3];
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];

  assign p1[0] = in_i.first_x;
  assign p1[1] = in_i.first_y;
  assign p1[2] = in_i.first_z;
  assign p2[0] = in_i.end_x;
  assign p2[1] = in_i.end_y;
  assign p2[2] = in_i.end_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d1_q[i] <= DW'(p2[i]) - DW'(p1[i]);
        s1_q[i] <= DW'(p1[i]) - DW'(vtx_q[i]);
        e1_q[i] <= DW'(vtx_q[3+i]) - DW'(vtx_q[i]);
        e2_q[i] <= DW'(vtx_q[6+i]) - DW'(vtx_q[i]);
      end
    end
  end

  // Stage 2: cross product terms for n = e1 x e2, s x e2, e1 x s
  logic signed [DW-1:0] xl [3][3];
  logic signed [DW-1:0] xr [3][3];
  logic signed [PW-1:0] pa_q [3][3];
  logic signed [PW-1:0] pb_q [3][3];
  logic signed [DW-1:0] d2_q [3];
  logic signed [DW-1:0] s2_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      xl[0][i] = e1_q[i]; xr[0][i] = e2_q[i];
      xl[1][i] = s1_q[i]; xr[1][i] = e2_q[i];
      xl[2][i] = e1_q[i]; xr[2][i] = s1_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q <= d1_q;
      s2_q <= s1_q;
      for (int c = 0; c < 3; c++) begin
        pa_q[c][0] <= xl[c][1] * xr[c][2];
        pb_q[c][0] <= xr[c][1] * xl[c][2];
        pa_q[c][1] <= xl[c][2] * xr[c][0];
        pb_q[c][1] <= xr[c][2] * xl[c][0];
        pa_q[c][2] <= xl[c][0] * xr[c][1];
        pb_q[c][2] <= xr[c][0] * xl[c][1];
      end
    end
  end

  // Stage 3: finish the cross products
  logic signed [CW-1:0] cr_q [3][3];
  logic signed [DW-1:0] d3_q [3];
  logic signed [DW-1:0] s3_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q <= d2_q;
      s3_q <= s2_q;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 3; i++) begin
          cr_q[c][i] <= CW'(pa_q[c][i]) - CW'(pb_q[c][i]);
        end
      end
    end
  end

  // Stages 4 to 6: the four dot products
  logic signed [SW-1:0] den6;
  logic signed [SW-1:0] sn6;
  logic signed [SW-1:0] uu6;
  logic signed [SW-1:0] vv6;

  stp_dot #(.W(W)) u_dot_den (
    .clk_i(clk_i), .en_i(en), .a_i(d3_q), .b_i(cr_q[0]), .dot_o(den6)
  );
  stp_dot #(.W(W)) u_dot_sn (
    .clk_i(clk_i), .en_i(en), .a_i(s3_q), .b_i(cr_q[0]), .dot_o(sn6)
  );
  stp_dot #(.W(W)) u_dot_uu (
    .clk_i(clk_i), .en_i(en), .a_i(d3_q), .b_i(cr_q[1]), .dot_o(uu6)
  );
  stp_dot #(.W(W)) u_dot_vv (
    .clk_i(clk_i), .en_i(en), .a_i(d3_q), .b_i(cr_q[2]), .dot_o(vv6)
  );

  // Stage 7: make the denominator non-negative
  logic signed [SW-1:0] den7_q;
  logic signed [SW-1:0] num7_q;
  logic signed [SW-1:0] uu7_q;
  logic signed [SW-1:0] vv7_q;
  logic                 zero7_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero7_q <= (den6 == '0);
      if (den6[SW-1]) begin
        den7_q <= -den6;
        num7_q <= sn6;
        uu7_q  <= -uu6;
        vv7_q  <= -vv6;
      end else begin
        den7_q <= den6;
        num7_q <= -sn6;
        uu7_q  <= uu6;
        vv7_q  <= vv6;
      end
    end
  end

  // Stage 8: hit decision, magnitude and overflow check
  localparam int BW = SW + QBits;
  logic              inside7;
  logic [SW-1:0]     mag7;
  stp_flags_t        flg8_q;
  logic [SW-1:0]     den8_q;
  logic [SW-1:0]     mag8_q;

  assign inside7 = !num7_q[SW-1] && (den7_q >= num7_q)
                && !uu7_q[SW-1] && (uu7_q != '0)
                && !vv7_q[SW-1] && (vv7_q != '0)
                && ((SW+1)'(uu7_q) + (SW+1)'(vv7_q) < (SW+1)'(den7_q));
  assign mag7 = num7_q[SW-1] ? SW'(-num7_q) : SW'(num7_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      flg8_q.hit  <= inside7;
      flg8_q.neg  <= num7_q[SW-1];
      flg8_q.zero <= zero7_q;
      flg8_q.big  <= BW'(mag7) >= (BW'(den7_q) << (QBits - OutFrac - 1));
      den8_q      <= SW'(den7_q);
      mag8_q      <= mag7;
    end
  end

  // Stages 9 to 42: quotient
  logic [QBits-1:0] quo;
  stp_flags_t       flg;

  stp_div #(.SW(SW)) u_div (
    .clk_i(clk_i), .en_i(en), .den_i(den8_q), .mag_i(mag8_q), .flg_i(flg8_q),
    .quo_o(quo), .flg_o(flg)
  );

  // Round, saturate and sign the fraction
  logic [QBits:0]              quo_inc;
  logic [QBits-1:0]            qr;
  logic [FracWidth-1:0]        res_frac;
  logic                        res_hit;

  assign quo_inc = (QBits+1)'(quo) + (QBits+1)'(1);

  always_comb begin
    qr = flg.big ? (QBits'(1) << (QBits - 1)) : quo_inc[QBits:1];
    if (flg.zero) begin
      res_frac = '0;
      res_hit  = 1'b0;
    end else begin
      res_hit = flg.hit;
      if (flg.neg) begin
        if (qr > (QBits'(1) << (FracWidth - 1))) begin
          res_frac = {1'b1, {(FracWidth-1){1'b0}}};
        end else begin
          res_frac = FracWidth'(~qr + QBits'(1));
        end
      end else begin
        if (qr > QBits'({1'b0, {(FracWidth-1){1'b1}}})) begin
          res_frac = {1'b0, {(FracWidth-1){1'b1}}};
        end else begin
          res_frac = FracWidth'(qr);
        end
      end
    end
  end

  // Load the output register, spill into the skid register when it is held
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (en) begin
      if (vld_q[LAT-1]) begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end else if (out_o.ready) begin
      skid_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (vld_q[LAT-1]) begin
        if (!out_vld_q || out_o.ready) begin
          out_hit_q  <= res_hit;
          out_frac_q <= res_frac;
        end else begin
          skid_hit_q  <= res_hit;
          skid_frac_q <= res_frac;
        end
      end
    end else if (out_o.ready) begin
      out_hit_q  <= skid_hit_q;
      out_frac_q <= skid_frac_q;
    end
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.hit      = out_hit_q;
  assign out_o.fraction = out_frac_q;

  // The skid register fills only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid word held with empty output register");

  // A stall freezes the words in flight
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // A hit always lies on the segment: 0 <= f <= 1.0
  a_hit_on_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_hit_q) |->
      (!out_frac_q[FracWidth-1] && out_frac_q <= (FracWidth'(1) << OutFrac)))
    else $error("hit reported with fraction outside the segment");

endmodule

[rtl/core/stp_dot.sv]
// Three-stage exact 3-term dot product of a short and a long signed vector.
module stp_dot
  import stp_pkg::*;
#(
  parameter int W = CoordWidthDef
) (
  input  logic clk_i,
  input  logic en_i,
  input  logic signed [W:0]       a_i [3],
  input  logic signed [2*W+2:0]   b_i [3],
  output logic signed [3*W+4:0]   dot_o
);
  localparam int DW = W + 1;
  localparam int CW = 2 * DW + 1;
  localparam int SW = 3 * DW + 2;
  localparam int LO = DW + 1;
  localparam int HI = CW - LO;
  localparam int LPW = DW + LO + 1;
  localparam int HPW = DW + HI;
  localparam int HSW = HPW + 2;
  localparam int LSW = LPW + 2;

  logic signed [LPW-1:0] plo_q [3];
  logic signed [HPW-1:0] phi_q [3];
  logic signed [HSW-1:0] hs_q;
  logic signed [LSW-1:0] ls_q;
  logic signed [SW-1:0]  dot_q;

  // Split the long operand: unsigned low half, signed high half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        plo_q[i] <= a_i[i] * $signed({1'b0, b_i[i][LO-1:0]});
        phi_q[i] <= a_i[i] * $signed(b_i[i][CW-1:LO]);
      end
    end
  end

  // Sum the partial products of each half
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hs_q <= HSW'(phi_q[0]) + HSW'(phi_q[1]) + HSW'(phi_q[2]);
      ls_q <= LSW'(plo_q[0]) + LSW'(plo_q[1]) + LSW'(plo_q[2]);
    end
  end

  // Recombine the halves
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dot_q <= (SW'(hs_q) <<< LO) + SW'(ls_q);
    end
  end

  assign dot_o = dot_q;

endmodule

[rtl/core/stp_div.sv]
// Pipelined restoring divider: one quotient bit per stage, flags ride along.
module stp_div
  import stp_pkg::*;
#(
  parameter int SW = 3 * CoordWidthDef + 5
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [SW-1:0]    den_i,
  input  logic [SW-1:0]    mag_i,
  input  stp_flags_t       flg_i,
  output logic [QBits-1:0] quo_o,
  output stp_flags_t       flg_o
);
  localparam int RW = SW + QBits;

  logic [RW-1:0]    rem_q [QBits];
  logic [SW-1:0]    den_q [QBits];
  logic [QBits-1:0] quo_q [QBits];
  stp_flags_t       flg_q [QBits];

  for (genvar j = 0; j < QBits; j++) begin : g_stage
    localparam int K = QBits - 1 - j;
    logic [RW-1:0]    rem_in;
    logic [SW-1:0]    den_in;
    logic [QBits-1:0] quo_in;
    stp_flags_t       flg_in;
    logic [RW-1:0]    trial;

    if (j == 0) begin : g_first
      assign rem_in = RW'(mag_i) << (OutFrac + 1);
      assign den_in = den_i;
      assign quo_in = '0;
      assign flg_in = flg_i;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
      assign flg_in = flg_q[j-1];
    end

    assign trial = RW'(den_in) << K;

    // Subtract the shifted divisor when it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[j] <= den_in;
        flg_q[j] <= flg_in;
        if (rem_in >= trial) begin
          rem_q[j] <= rem_in - trial;
          quo_q[j] <= quo_in | (QBits'(1) << K);
        end else begin
          rem_q[j] <= rem_in;
          quo_q[j] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[QBits-1];
  assign flg_o = flg_q[QBits-1];

endmodule
